// ===== src/pvsd_pkg.sv =====
// Shared types, constants and helpers for the prefix varint stream decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pvsd_pkg;

  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned VALUE_W   = 60;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned LIMIT_LSB = ACC_W - 7;

  localparam logic [0:0]  REG_DEST_BYTES   = 1'b0;
  localparam logic [3:0]  DEST_BYTES_RESET = 4'd8;

  localparam logic [11:0] LEN12_ESCAPE = 12'hFFF;
  localparam logic [31:0] LEN32_ESCAPE = 32'hFFFF_FFFF;
  localparam logic [3:0]  LEN32_BYTES  = 4'd4;
  localparam logic [3:0]  LEN64_BYTES  = 4'd8;
  localparam logic [3:0]  SHORT2_BYTES = 4'd2;
  localparam logic [3:0]  SHORT4_BYTES = 4'd4;
  localparam logic [3:0]  SHORT8_BYTES = 4'd8;

  typedef enum logic [2:0] {
    KIND_VALUE    = 3'd0,
    KIND_LENGTH   = 3'd1,
    KIND_OVERFLOW = 3'd2,
    KIND_LIMIT    = 3'd3,
    KIND_OVERRUN  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SHORT = 3'd1,
    PH_LEN12 = 3'd2,
    PH_LEN32 = 3'd3,
    PH_LEN64 = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_mark;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
  } result_t;

  // Bits that must be clear for a value to fit the destination width.
  function automatic logic [ACC_W-1:0] high_mask(input logic [3:0] db);
    logic [ACC_W-1:0] m;
    begin
      case (db)
        4'd0, 4'd1: m = 64'hFFFF_FFFF_FFFF_FF00;
        4'd2:       m = 64'hFFFF_FFFF_FFFF_0000;
        4'd3:       m = 64'hFFFF_FFFF_FF00_0000;
        4'd4:       m = 64'hFFFF_FFFF_0000_0000;
        4'd5:       m = 64'hFFFF_FF00_0000_0000;
        4'd6:       m = 64'hFFFF_0000_0000_0000;
        4'd7:       m = 64'hFF00_0000_0000_0000;
        default:    m = '0;
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/pvsd_apb_regs.sv =====
// APB register file of the decoder: the destination width register.
// Depends on pvsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvsd_apb_regs
  import pvsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [3:0]        dest_bytes
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[ADDR_W-1] == REG_DEST_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_bytes <= DEST_BYTES_RESET;
    end else if (wr_en) begin
      dest_bytes <= pwdata[3:0];
    end
  end

  always_comb begin
    if (paddr[ADDR_W-1] == REG_DEST_BYTES) begin
      prdata = {{(DATA_W-4){1'b0}}, dest_bytes};
    end else begin
      prdata = '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/pvsd_in_stage.sv =====
// Input register of the decoder: holds one byte beat until the parser takes it.
// Depends on pvsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvsd_in_stage
  import pvsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  byte_valid,
  output logic       byte_ready,
  input  wire item_t item_in,
  input  wire logic  advance,
  output logic       item_valid,
  output item_t      item
);

  assign byte_ready = ~item_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (byte_ready) begin
      item_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid & byte_ready) begin
      item <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/pvsd_parser.sv =====
// Parse state machine: consumes one registered byte per advance and forms results.
// Depends on pvsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvsd_parser
  import pvsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire item_t      item,
  input  wire logic [3:0] dest_bytes,
  output logic            res_fire,
  output result_t         res
);

  phase_t           phase, phase_next;
  logic [3:0]       needed, needed_next;
  logic [3:0]       taken, taken_next;
  logic [ACC_W-1:0] acc, acc_next;

  logic [7:0]       b;
  logic [3:0]       taken_inc;
  logic [ACC_W-1:0] gathered;
  logic [ACC_W-1:0] short_val;
  logic [11:0]      len12;

  assign b         = item.data_byte;
  assign taken_inc = taken + 4'd1;
  assign gathered  = acc | ({{(ACC_W-8){1'b0}}, b} << {taken[2:0], 3'b000});
  assign len12     = {b, acc[7:4]};

  always_comb begin
    if (needed == SHORT2_BYTES) begin
      short_val = gathered >> 2;
    end else if (needed == SHORT4_BYTES) begin
      short_val = gathered >> 3;
    end else begin
      short_val = gathered >> 4;
    end
  end

  // next state
  always_comb begin
    phase_next  = phase;
    needed_next = needed;
    taken_next  = taken;
    acc_next    = acc;
    if (item.end_mark) begin
      phase_next  = PH_IDLE;
      needed_next = '0;
      taken_next  = '0;
      acc_next    = '0;
    end else begin
      case (phase)
        PH_SHORT: begin
          acc_next   = gathered;
          taken_next = taken_inc;
          if (taken_inc >= needed) begin
            phase_next  = PH_IDLE;
            needed_next = '0;
            taken_next  = '0;
            acc_next    = '0;
          end
        end
        PH_LEN12: begin
          phase_next  = (len12 == LEN12_ESCAPE) ? PH_LEN32 : PH_IDLE;
          needed_next = (len12 == LEN12_ESCAPE) ? LEN32_BYTES : 4'd0;
          taken_next  = '0;
          acc_next    = '0;
        end
        PH_LEN32: begin
          acc_next   = gathered;
          taken_next = taken_inc;
          if (taken_inc >= LEN32_BYTES) begin
            phase_next  = (gathered == {32'd0, LEN32_ESCAPE}) ? PH_LEN64 : PH_IDLE;
            needed_next = (gathered == {32'd0, LEN32_ESCAPE}) ? LEN64_BYTES : 4'd0;
            taken_next  = '0;
            acc_next    = '0;
          end
        end
        PH_LEN64: begin
          acc_next   = gathered;
          taken_next = taken_inc;
          if (taken_inc >= LEN64_BYTES) begin
            phase_next  = PH_IDLE;
            needed_next = '0;
            taken_next  = '0;
            acc_next    = '0;
          end
        end
        default: begin
          phase_next  = PH_IDLE;
          needed_next = '0;
          taken_next  = '0;
          acc_next    = '0;
          if (b[0]) begin
            acc_next   = {{(ACC_W-8){1'b0}}, b};
            taken_next = 4'd1;
            if (!b[1]) begin
              phase_next  = PH_SHORT;
              needed_next = SHORT2_BYTES;
            end else if (!b[2]) begin
              phase_next  = PH_SHORT;
              needed_next = SHORT4_BYTES;
            end else if (!b[3]) begin
              phase_next  = PH_SHORT;
              needed_next = SHORT8_BYTES;
            end else begin
              phase_next  = PH_LEN12;
              needed_next = SHORT2_BYTES;
            end
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_fire  = 1'b0;
    res.kind  = KIND_VALUE;
    res.value = '0;
    if (item.end_mark) begin
      if (phase != PH_IDLE) begin
        res_fire = 1'b1;
        res.kind = KIND_OVERRUN;
      end
    end else begin
      case (phase)
        PH_SHORT: begin
          if (taken_inc >= needed) begin
            res_fire = 1'b1;
            if ((short_val & high_mask(dest_bytes)) != '0) begin
              res.kind = KIND_OVERFLOW;
            end else begin
              res.value = short_val[VALUE_W-1:0];
            end
          end
        end
        PH_LEN12: begin
          if (len12 != LEN12_ESCAPE) begin
            res_fire  = 1'b1;
            res.kind  = KIND_LENGTH;
            res.value = {{(VALUE_W-14){1'b0}}, len12, 2'b00};
          end
        end
        PH_LEN32: begin
          if (taken_inc >= LEN32_BYTES && gathered != {32'd0, LEN32_ESCAPE}) begin
            res_fire  = 1'b1;
            res.kind  = KIND_LENGTH;
            res.value = {{(VALUE_W-34){1'b0}}, gathered[31:0], 2'b00};
          end
        end
        PH_LEN64: begin
          if (taken_inc >= LEN64_BYTES) begin
            res_fire = 1'b1;
            if (gathered == '1 || gathered[ACC_W-1:LIMIT_LSB] != '0) begin
              res.kind = KIND_LIMIT;
            end else begin
              res.kind  = KIND_LENGTH;
              res.value = {gathered[VALUE_W-3:0], 2'b00};
            end
          end
        end
        default: begin
          if (!b[0]) begin
            res_fire  = 1'b1;
            res.value = {{(VALUE_W-7){1'b0}}, b[7:1]};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      needed <= '0;
      taken  <= '0;
      acc    <= '0;
    end else if (advance) begin
      phase  <= phase_next;
      needed <= needed_next;
      taken  <= taken_next;
      acc    <= acc_next;
    end
  end

`ifndef ASSERT_OFF
  a_short_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SHORT |->
      (needed == SHORT2_BYTES || needed == SHORT4_BYTES || needed == SHORT8_BYTES))
    else $error("short form with bad byte count");
  a_short_taken: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SHORT |-> (taken != 4'd0 && taken < needed))
    else $error("short form byte count out of range");
  a_len_taken: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_LEN32 || taken < LEN32_BYTES) &&
    (phase != PH_LEN64 || taken < LEN64_BYTES))
    else $error("length byte count out of range");
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> (acc == '0 && taken == 4'd0))
    else $error("idle with stale accumulator");
`endif

endmodule

`default_nettype wire

// ===== src/pvsd_out_stage.sv =====
// Output register of the decoder: holds one result beat until it is taken.
// Depends on pvsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvsd_out_stage
  import pvsd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res,
  output logic         space,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      held
);

  assign space = ~result_valid | result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

`default_nettype wire

// ===== src/prefix_varint_stream_decoder_core.sv =====
// Prefix varint stream decoder: one encoded byte per beat, one result per quantity.
// A result passes the input register, the parse logic and the output register, and waits while the output is full.
// Throughput: one byte per cycle while the output register has space, set by the parse stage behind the input register.
// Reset (rst, synchronous): parser idle, both stages empty, dest_bytes = 8.
// Depends on pvsd_pkg, pvsd_apb_regs, pvsd_in_stage, pvsd_parser, pvsd_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module prefix_varint_stream_decoder_core
  import pvsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  input  wire logic               byte_valid,
  output logic                    byte_ready,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_mark,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic      [2:0]         result_kind,
  output logic      [VALUE_W-1:0] result_value
);

  logic [3:0] dest_bytes;
  item_t      item_in, item;
  logic       item_valid;
  logic       space;
  logic       advance;
  logic       res_fire;
  result_t    res, held;

  assign item_in = '{data_byte: data_byte, end_mark: end_mark};
  assign advance = item_valid & space;

  pvsd_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .dest_bytes (dest_bytes)
  );

  pvsd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .item_in    (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pvsd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (item),
    .dest_bytes (dest_bytes),
    .res_fire   (res_fire),
    .res        (res)
  );

  pvsd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance & res_fire),
    .res          (res),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .held         (held)
  );

  assign result_kind  = held.kind;
  assign result_value = held.value;

endmodule

`default_nettype wire
